// File: hw/rtl/msort_pkg.sv
// Shared types and constants for the merge sort engine.
// Holds the cell operation codes and the control bundle that the chain of
// cells receives. No dependencies.
package msort_pkg;

  localparam int DataW    = 32;
  localparam int DefDepth = 64;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SHL,
    OP_SHR
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] x;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/msort_cell.sv
// One cell of the sorting chain: holds a single value and its valid bit.
// Depends on msort_pkg for the operation codes and the control bundle.
module msort_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  msort_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [msort_pkg::DataW-1:0]  left_value_i,
  input  logic                                left_valid_i,
  input  logic                                left_lt_i,
  input  logic signed [msort_pkg::DataW-1:0]  right_value_i,
  input  logic                                right_valid_i,
  output logic signed [msort_pkg::DataW-1:0]  value_o,
  output logic                                valid_o,
  output logic                                lt_o
);
  import msort_pkg::*;

  logic signed [DataW-1:0] value_q, value_d;
  logic                    valid_q, valid_d;
  logic                    lt;

  // An empty cell acts as plus infinity, so the new value belongs here or below.
  assign lt = !valid_q || (ctrl_i.x < value_q);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (left_lt_i) begin
          value_d = left_value_i;
          valid_d = left_valid_i;
        end else if (lt) begin
          value_d = ctrl_i.x;
          valid_d = 1'b1;
        end
      end
      OP_SHL: begin
        value_d = right_value_i;
        valid_d = right_valid_i;
      end
      OP_SHR: begin
        value_d = left_value_i;
        valid_d = left_valid_i;
      end
      default: begin
        value_d = value_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;
  assign lt_o    = lt;

endmodule

// File: hw/rtl/msort_chain.sv
// Row of sorting cells wired to their neighbors, lowest value at cell 0.
// Depends on msort_pkg and msort_cell.
module msort_chain #(
  parameter int Depth = msort_pkg::DefDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msort_pkg::cell_ctrl_t              ctrl_i,
  output logic signed [msort_pkg::DataW-1:0] head_value_o,
  output logic signed [msort_pkg::DataW-1:0] tail_value_o,
  output logic                               tail_valid_o
);
  import msort_pkg::*;

  logic signed [DataW-1:0] value_w [Depth];
  logic                    valid_w [Depth];
  logic                    lt_w    [Depth];

  for (genvar gi = 0; gi < Depth; gi++) begin : g_cell
    logic signed [DataW-1:0] lval;
    logic signed [DataW-1:0] rval;
    logic                    lvalid;
    logic                    llt;
    logic                    rvalid;

    if (gi == 0) begin : g_first
      assign lval   = '0;
      assign lvalid = 1'b0;
      assign llt    = 1'b0;
    end else begin : g_left
      assign lval   = value_w[gi-1];
      assign lvalid = valid_w[gi-1];
      assign llt    = lt_w[gi-1];
    end

    if (gi == Depth - 1) begin : g_top
      assign rval   = '0;
      assign rvalid = 1'b0;
    end else begin : g_right
      assign rval   = value_w[gi+1];
      assign rvalid = valid_w[gi+1];
    end

    msort_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .left_value_i  (lval),
      .left_valid_i  (lvalid),
      .left_lt_i     (llt),
      .right_value_i (rval),
      .right_valid_i (rvalid),
      .value_o       (value_w[gi]),
      .valid_o       (valid_w[gi]),
      .lt_o          (lt_w[gi])
    );
  end

  assign head_value_o = value_w[0];
  assign tail_value_o = value_w[Depth-1];
  assign tail_valid_o = valid_w[Depth-1];

endmodule

// File: hw/rtl/merge_sort_engine_unit.sv
// Top level of the merge sort engine: load control, unload sequencing, output register.
// Depends on msort_pkg and msort_chain (which uses msort_cell).
//
// The engine collects a set of signed 32-bit values, one per input beat, until a
// beat with tlast arrives, and then streams the set back out sorted, one value per
// output beat, with tlast on the final value. Sorting happens while the set loads:
// every value is inserted into a row of Depth cells, one cell per value, each cell
// comparing the new value with its own and either keeping its value, taking the new
// one or taking its lower neighbor's, so each beat is inserted as it is taken. The sort
// direction is the ascending register as it stands when the tlast beat is taken;
// ascending sets unload from the bottom cell, descending sets first shift the row up
// until the top cell holds data and then unload from the top. Unloading delivers one
// beat per cycle while the sink is ready. Input is not taken while a set is aligning
// or unloading. Beats beyond Depth in one set are discarded, and every output beat
// of that set then has tuser (dropped) set; a discarded beat with tlast still ends
// the set.
module merge_sort_engine_unit #(
  parameter int Depth = msort_pkg::DefDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: bit 0 is ascending (1 smallest first, 0 largest first).
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_wdata_i,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [msort_pkg::DataW-1:0]       s_axis_tdata_i,  // [31:0] value
  input  logic                              s_axis_tlast_i,  // last
  // Output stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [msort_pkg::DataW-1:0]       m_axis_tdata_o,  // [31:0] value_res
  output logic                              m_axis_tlast_o,  // last_res
  output logic [0:0]                        m_axis_tuser_o   // [0] dropped
);
  import msort_pkg::*;

  localparam int CntW = $clog2(Depth + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_ALIGN  = 2'd1;
  localparam logic [1:0] ST_UNLOAD = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;
  logic            ovf_q, ovf_d;
  logic            asc_cfg_q;
  logic            asc_q, asc_d;

  logic             m_valid_q, m_valid_d;
  logic [DataW-1:0] m_data_q, m_data_d;
  logic             m_last_q, m_last_d;
  logic             m_user_q, m_user_d;

  cell_ctrl_t              ctrl;
  logic signed [DataW-1:0] head_value;
  logic signed [DataW-1:0] tail_value;
  logic                    tail_valid;

  logic in_fire;
  logic room;
  logic out_free;
  logic pop;

  assign s_axis_tready_o = (state_q == ST_LOAD);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign room            = (count_q < CntW'(Depth));
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign pop             = (state_q == ST_UNLOAD) && out_free;

  // Commands to the cell row.
  always_comb begin
    ctrl.x  = s_axis_tdata_i;
    ctrl.op = OP_HOLD;
    if (in_fire && room) begin
      ctrl.op = OP_LOAD;
    end else if ((state_q == ST_ALIGN) && !tail_valid) begin
      ctrl.op = OP_SHR;
    end else if (pop) begin
      ctrl.op = asc_q ? OP_SHL : OP_SHR;
    end
  end

  // Set sequencing.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    ovf_d    = ovf_q;
    asc_d    = asc_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          count_d = room ? count_q + CntW'(1) : count_q;
          ovf_d   = ovf_q || !room;
          if (s_axis_tlast_i) begin
            remain_d = count_d;
            asc_d    = asc_cfg_q;
            state_d  = asc_cfg_q ? ST_UNLOAD : ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        if (tail_valid) begin
          state_d = ST_UNLOAD;
        end
      end
      ST_UNLOAD: begin
        if (out_free) begin
          remain_d = remain_q - CntW'(1);
          if (remain_q == CntW'(1)) begin
            state_d = ST_LOAD;
            count_d = '0;
            ovf_d   = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // Output register: a sorted value moves here while the previous beat drains.
  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_last_d  = m_last_q;
    m_user_d  = m_user_q;
    if (pop) begin
      m_valid_d = 1'b1;
      m_data_d  = asc_q ? head_value : tail_value;
      m_last_d  = (remain_q == CntW'(1));
      m_user_d  = ovf_q;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      remain_q  <= '0;
      ovf_q     <= 1'b0;
      asc_cfg_q <= 1'b1;
      asc_q     <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      remain_q  <= remain_d;
      ovf_q     <= ovf_d;
      asc_q     <= asc_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        asc_cfg_q <= cfg_wdata_i[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  msort_chain #(
    .Depth (Depth)
  ) u_chain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .head_value_o (head_value),
    .tail_value_o (tail_value),
    .tail_valid_o (tail_valid)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTH
  // The fill count never passes the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("fill count exceeds depth");

  // Unloading always has at least one value left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNLOAD) |-> (remain_q != '0))
    else $error("unload with nothing remaining");

  // A descending unload reads the top cell, which must hold data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UNLOAD) && !asc_q) |-> tail_valid)
    else $error("descending unload from empty top cell");

  // The end of a set stops further input until it has been sent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && s_axis_tlast_i) |=> !s_axis_tready_o)
    else $error("input taken right after end of set");
`endif

endmodule

// File: tb/tb.sv
// Self-checking testbench for merge_sort_engine_unit.
// Depends on msort_pkg and the engine RTL. It holds a small scoreboard class
// that predicts the sorted output of each set, and plain tasks drive the streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msort_pkg::*;

  localparam int Depth         = DefDepth;
  // Margin of idle time after the last predicted beat has come out.
  localparam int SettleCycles  = Depth + 8;
  localparam int ItemsTotal    = 420;
  // Beats sent by the directed sets before the random phases.
  localparam int DirectedItems = 20;
  localparam int PhaseItems    = (ItemsTotal - DirectedItems) / 3;

  typedef logic signed [DataW-1:0] elem_t;

  typedef struct {
    elem_t value;
    logic  last;
    logic  dropped;
  } sorted_beat_t;

  // Scoreboard: collects the values of the set being loaded, sorts them when the
  // beat with tlast arrives, and checks each output beat against the oldest
  // predicted beat.
  class sort_scoreboard;
    elem_t        pending_set[$];
    bit           overflow_seen;
    bit           ascending = 1'b1;
    sorted_beat_t sorted_beats[$];
    int           errors;

    function void set_order(bit asc);
      ascending = asc;
    endfunction

    function void note_input(elem_t v, logic last);
      elem_t        ordered[$];
      elem_t        t;
      int           i;
      int           j;
      sorted_beat_t b;
      if (pending_set.size() < Depth) begin
        pending_set.insert(pending_set.size(), v);
      end else begin
        overflow_seen = 1'b1;
      end
      if (!last) return;
      // Insertion sort. Equal values are indistinguishable, so stability does
      // not matter.
      ordered = pending_set;
      for (i = 1; i < ordered.size(); i++) begin
        t = ordered[i];
        j = i - 1;
        while (j >= 0 && (ascending ? (ordered[j] > t) : (ordered[j] < t))) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = t;
      end
      foreach (ordered[k]) begin
        b.value   = ordered[k];
        b.last    = (k == ordered.size() - 1);
        b.dropped = overflow_seen;
        sorted_beats.insert(sorted_beats.size(), b);
      end
      pending_set.delete();
      overflow_seen = 1'b0;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_beat(elem_t v, logic last, logic dropped);
      sorted_beat_t want;
      if (sorted_beats.size() == 0) begin
        flag_mismatch($sformatf("output beat %0d with no beat predicted", v));
        return;
      end
      want = sorted_beats.pop_front();
      if (v !== want.value)
        flag_mismatch($sformatf("value %0d, predicted %0d", v, want.value));
      if (last !== want.last)
        flag_mismatch($sformatf("tlast %b, predicted %b", last, want.last));
      if (dropped !== want.dropped)
        flag_mismatch($sformatf("dropped %b, predicted %b", dropped, want.dropped));
    endtask
  endclass

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [0:0]  cfg_wdata_i     = 1'b1;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  elem_t       s_axis_tdata_i  = '0;   // [31:0] value
  logic        s_axis_tlast_i  = 1'b0; // last
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  elem_t       m_axis_tdata_o;         // [31:0] value_res
  logic        m_axis_tlast_o;         // last_res
  logic [0:0]  m_axis_tuser_o;         // [0] dropped

  // Percentages of cycles in which the sender or the receiver holds back.
  int src_gap_pct = 0;
  int snk_gap_pct = 0;

  sort_scoreboard sb = new;

  merge_sort_engine_unit #(
    .Depth (Depth)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // Receiver: checks every output beat taken at this edge, then decides whether
  // it will be ready at the next one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_beat(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o[0]);
    end
    m_axis_tready_i <= ($urandom_range(99) >= snk_gap_pct);
  end

  // Drives one input beat and returns in the time step in which it was taken.
  // tvalid is left high so that a following beat can go out back to back; every
  // caller either sends again or lowers tvalid in that same step.
  task automatic send_beat(elem_t v, logic last);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(posedge clk_i);
    sb.note_input(v, last);
  endtask

  // Holds the input until every predicted beat has come out, then lets the
  // engine settle so that it is idle.
  task automatic pause_until_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.sorted_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Changes the sort direction. The engine is made idle first.
  task automatic write_order(bit asc);
    pause_until_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= asc;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_order(asc);
  endtask

  // Mostly random values, with extremes and a narrow range that makes
  // duplicates common.
  function automatic elem_t pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2:    return elem_t'($urandom_range(8)) - 4;
      default: return elem_t'($urandom);
    endcase
  endfunction

  // Set lengths: mostly short, some medium, and a few around or beyond the depth
  // so that the drop path and a discarded tlast beat get exercised.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(Depth - 2, Depth + 6);
    if (r < 15) return $urandom_range(13, 40);
    return $urandom_range(1, 12);
  endfunction

  task automatic send_set(int n);
    for (int i = 0; i < n; i++) begin
      send_beat(pick_value(), i == n - 1);
    end
  endtask

  // Extremes of the value range, with repeats, in one set.
  task automatic send_corner_set();
    elem_t corner[7];
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1,
               32'h8000_0000, 32'h7FFF_FFFF};
    foreach (corner[i]) send_beat(corner[i], i == 6);
  endtask

  task automatic run_phase(int src_pct, int snk_pct, bit asc, int first_len);
    int sent;
    int n;
    write_order(asc);
    src_gap_pct = src_pct;
    snk_gap_pct = snk_pct;
    send_set(first_len);
    sent = first_len;
    while (sent < PhaseItems) begin
      if ($urandom_range(99) < 8) write_order($urandom_range(1));
      n = pick_length();
      send_set(n);
      sent += n;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sets, first with the reset direction (ascending).
    src_gap_pct = 17;
    snk_gap_pct = 88;
    send_beat(32'h7FFF_FFFF, 1'b1);  // a set of one
    send_corner_set();
    send_beat(-5, 1'b0);             // two equal values
    send_beat(-5, 1'b1);
    write_order(1'b0);
    send_corner_set();
    send_beat(32'h8000_0000, 1'b1);
    send_beat(32'h0000_0000, 1'b0);
    send_beat(32'hFFFF_FFFF, 1'b1);

    // Random phases. The first set of each is a full store, one beat past it
    // (so the tlast beat itself is discarded), and a clearly overfull set.
    run_phase(17, 88, 1'b1, Depth);
    run_phase(88, 17, 1'b0, Depth + 1);
    run_phase(0, 0, 1'b1, Depth + 6);

    pause_until_drained();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/msort_pkg.sv
hw/rtl/msort_cell.sv
hw/rtl/msort_chain.sv
hw/rtl/merge_sort_engine_unit.sv
tb/tb.sv
